FILE: rtl/lidar_range_fir_filter_assert.svh
// Assertion macros for the port-level checker of the lidar range filter.
`ifndef LIDAR_RANGE_FIR_FILTER_ASSERT_SVH
`define LIDAR_RANGE_FIR_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LRF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define LRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lrff_pkg.sv
// Package with the types, constants and defaults of the lidar range filter.
`timescale 1ns / 1ps

package lrff_pkg;

   // Defaults for the top-level parameters.
   localparam int FILTER_ORDER_DEF = 4;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int PHASE_PAD_DEF    = 4;
   localparam int MAX_SCAN_LEN_DEF = 1024;

   // Input word: only the low bits carry the range.
   localparam int SAMPLE_WORD_W = 16;
   localparam int SAMPLE_BITS   = 13;

   // Coefficient registers.
   localparam int NUM_REGS    = 5;
   localparam int REG_IDX_W   = $clog2(NUM_REGS);
   localparam int CSR_INDEX_W = 3;
   localparam int COEFF_RAW_W = 16;
   localparam int COEFF_W     = 17;

   // Datapath widths.
   localparam int SUM_W   = 32;
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

   // Division of a 32-bit magnitude by 100 through a reciprocal multiply.
   localparam logic [MUL_A_W-1:0] DIV100_MAGIC = 32'h51EB851F;
   localparam int DIV100_SHIFT = 37;
   localparam int QM_W         = 26;

   // Output mapping.
   localparam int RANGE_T_W = 16;
   localparam int RANGE_W   = 8;
   localparam logic [RANGE_W-1:0] RANGE_MAX          = 8'hff;
   localparam logic [RANGE_W-1:0] RANGE_OUT_OF_RANGE = 8'd0;
   localparam logic [RANGE_W-1:0] RANGE_MIN_CODE     = 8'd1;

   typedef struct packed {
      logic [SAMPLE_WORD_W-1:0] sample_word;
      logic                     scan_end;
   } req_data_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_byte;
      logic               last_out;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_SUM,
      ST_SCALE,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/lidar_range_fir_filter.sv
// Lidar range FIR filter: shared multiply-accumulate under a small sequencer.
`timescale 1ns / 1ps
// Usage. Range words enter on the req_ channel (valid/ready) as a sample word and a
// scan end flag; filtered range bytes leave on the rsp_ channel with a last flag on
// the final result of a scan. Coefficients are written on the csr_ channel; index 0
// to 4 select the tap registers and higher indexes are accepted and ignored.
// Each write to a tap register runs a short conversion (folding division by 2^F-1)
// that keeps the block busy; csr_ready and req_ready are low meanwhile. A filter
// run uses the shared multiplier once per tap, then closes the sum, then runs the
// divide-by-100 multiply on the same multiplier and then places the result. A kept
// item causes one run, plus PHASE_PAD padding runs when it ends a scan; an item
// past MAX_SCAN_LEN causes no run of its own, and if it ends a scan it causes the
// PHASE_PAD padding runs alone.
// The block takes one item at a time; req_ready is high only while it is idle.
// Results wait in an output register; when the receiver stalls the sequencer holds
// in its last step until the register frees, and a new item can be accepted while
// the final result of the previous one still waits.
// Reset (synchronous, active high) clears the coefficients, delay line, scan
// position, last sample and the output valid flag.
module lidar_range_fir_filter
   import lrff_pkg::*;
#(
   parameter int FILTER_ORDER = FILTER_ORDER_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int PHASE_PAD    = PHASE_PAD_DEF,
   parameter int MAX_SCAN_LEN = MAX_SCAN_LEN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_data_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEFF_RAW_W-1:0] csr_data
);

   // Scaled sample width, tap counter, pad counter and scan position widths.
   localparam int XW    = SAMPLE_BITS + FRAC_BITS;
   localparam int TAP_W = $clog2(FILTER_ORDER + 1);
   localparam int PAD_W = (PHASE_PAD > 0) ? $clog2(PHASE_PAD + 1) : 1;
   localparam int SP_W  = $clog2(MAX_SCAN_LEN + 1);
   localparam int CMP_W = ((SP_W > PAD_W) ? SP_W : PAD_W) + 1;
   localparam int QE_W  = QM_W + 1 + FRAC_BITS;
   // Coefficient conversion works on the raw magnitude against 2^F-1.
   localparam int CNV_W = ((FRAC_BITS > COEFF_RAW_W) ? FRAC_BITS : COEFF_RAW_W) + 1;
   localparam logic [CNV_W-1:0] DEN = CNV_W'((64'd1 << FRAC_BITS) - 64'd1);

   // Sequencer and datapath registers.
   state_type               state_ff, state_in;
   logic [TAP_W-1:0]        tap_ff, tap_in;
   logic [PAD_W-1:0]        pad_cnt_ff, pad_cnt_in;
   logic [SP_W-1:0]         scan_pos_ff, scan_pos_in;
   logic [XW-1:0]           last_ff, last_in;
   logic [XW-1:0]           cur_x_ff, cur_x_in;
   logic [XW-1:0]           delay_ff [FILTER_ORDER];
   logic [XW-1:0]           delay_in [FILTER_ORDER];
   logic                    end_ff, end_in;
   logic                    emit_ff, emit_in;
   logic                    final_ff, final_in;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;

   // Coefficient registers and their conversion unit.
   logic signed [COEFF_W-1:0] coeff_ff [NUM_REGS];
   logic signed [COEFF_W-1:0] coeff_in [NUM_REGS];
   logic                      cnv_busy_ff, cnv_busy_in;
   logic [REG_IDX_W-1:0]      cnv_idx_ff, cnv_idx_in;
   logic                      cnv_neg_ff, cnv_neg_in;
   logic [COEFF_RAW_W-1:0]    cnv_mag_ff, cnv_mag_in;
   logic [CNV_W-1:0]          cnv_n_ff, cnv_n_in;
   logic [CNV_W-1:0]          cnv_q_ff, cnv_q_in;

   // Shared multiplier operands and helpers.
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic signed [COEFF_W-1:0] coef_sel;
   logic [XW-1:0]             x_sel;
   logic signed [PROD_W-1:0]  prod_shift;
   logic [SUM_W-1:0]          acc_mag;
   logic [QM_W-1:0]           q_mag;
   logic signed [QM_W:0]      q_val;
   logic signed [QE_W-1:0]    q_ext;
   logic signed [QE_W-1:0]    q_shift;
   logic [RANGE_T_W-1:0]      range_t;
   logic [RANGE_W-1:0]        range_code;
   logic                      out_free;
   logic [XW-1:0]             x_new;
   logic                      keep;
   logic [CNV_W-1:0]          cnv_hi;
   logic [CNV_W-1:0]          cnv_lo;
   logic [CNV_W-1:0]          cnv_qf;
   logic [COEFF_W-1:0]        cnv_sum;
   logic [COEFF_RAW_W-1:0]    raw_mag;

   assign req_ready = (state_ff == ST_IDLE) && !cnv_busy_ff;
   assign csr_ready = !cnv_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The one multiplier: taps during ST_MAC, the reciprocal of 100 during ST_SCALE
   // and ST_EMIT.
   assign prod_in    = mul_a * $signed({1'b0, mul_b});
   assign prod_shift = prod_ff >>> FRAC_BITS;

   // Magnitude of the wrapped sum for the divide by 100.
   assign acc_mag = acc_ff[SUM_W-1] ? (SUM_W'(0) - acc_ff) : acc_ff;

   // Quotient by 100, truncated toward zero, then the floor shift by FRAC_BITS-1.
   assign q_mag   = prod_ff[DIV100_SHIFT +: QM_W];
   assign q_val   = neg_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
   assign q_ext   = QE_W'(q_val);
   assign q_shift = q_ext >>> (FRAC_BITS - 1);
   assign range_t = q_shift[RANGE_T_W-1:0];

   always_comb begin
      if (range_t > RANGE_T_W'(RANGE_MAX)) begin
         range_code = RANGE_OUT_OF_RANGE;
      end else if (range_t == '0) begin
         range_code = RANGE_MIN_CODE;
      end else begin
         range_code = range_t[RANGE_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign x_new    = {req_data.sample_word[SAMPLE_BITS-1:0], FRAC_BITS'(0)};
   assign keep     = scan_pos_ff < SP_W'(MAX_SCAN_LEN);

   // Tap operand selection: coefficient k and the sample k steps back.
   always_comb begin
      coef_sel = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (int'(tap_ff) == i) begin
            coef_sel = coeff_ff[i];
         end
      end
      x_sel = cur_x_ff;
      for (int i = 0; i < FILTER_ORDER; i++) begin
         if (int'(tap_ff) == i + 1) begin
            x_sel = delay_ff[i];
         end
      end
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      pad_cnt_in   = pad_cnt_ff;
      scan_pos_in  = scan_pos_ff;
      last_in      = last_ff;
      cur_x_in     = cur_x_ff;
      delay_in     = delay_ff;
      end_in       = end_ff;
      emit_in      = emit_ff;
      final_in     = final_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = MUL_A_W'(coef_sel);
      mul_b        = MUL_B_W'(x_sel);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               end_in = req_data.scan_end;
               tap_in = '0;
               if (keep) begin
                  // A kept sample: one run on the new sample, then padding if it ends.
                  cur_x_in    = x_new;
                  last_in     = x_new;
                  emit_in     = CMP_W'(scan_pos_ff) >= CMP_W'(PHASE_PAD);
                  final_in    = req_data.scan_end && (PHASE_PAD == 0);
                  scan_pos_in = scan_pos_ff + SP_W'(1);
                  pad_cnt_in  = '0;
                  state_in    = ST_MAC;
               end else if (req_data.scan_end && (PHASE_PAD > 0)) begin
                  // Dropped scan end: padding still runs on the last kept sample.
                  cur_x_in   = last_ff;
                  emit_in    = CMP_W'(scan_pos_ff) >= CMP_W'(PHASE_PAD);
                  final_in   = (PHASE_PAD == 1);
                  pad_cnt_in = PAD_W'(1);
                  state_in   = ST_MAC;
               end else if (req_data.scan_end) begin
                  scan_pos_in = '0;
               end
            end
         end
         ST_MAC: begin
            acc_in = (tap_ff == '0) ? '0 : (acc_ff + prod_shift[SUM_W-1:0]);
            if (tap_ff == TAP_W'(FILTER_ORDER)) begin
               state_in = ST_SUM;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         ST_SUM: begin
            acc_in      = acc_ff + prod_shift[SUM_W-1:0];
            delay_in[0] = cur_x_ff;
            for (int i = 1; i < FILTER_ORDER; i++) begin
               delay_in[i] = delay_ff[i-1];
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mul_a    = $signed(DIV100_MAGIC);
            mul_b    = acc_mag;
            neg_in   = acc_ff[SUM_W-1];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // The scaling product is recomputed so it stays put while the result waits.
            mul_a = $signed(DIV100_MAGIC);
            mul_b = acc_mag;
            if (!emit_ff || out_free) begin
               if (emit_ff) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.range_byte = range_code;
                  rsp_data_in.last_out   = final_ff;
               end
               tap_in = '0;
               if (end_ff && (pad_cnt_ff != PAD_W'(PHASE_PAD))) begin
                  cur_x_in   = last_ff;
                  emit_in    = (CMP_W'(scan_pos_ff) + CMP_W'(pad_cnt_ff))
                               >= CMP_W'(PHASE_PAD);
                  final_in   = (CMP_W'(pad_cnt_ff) + CMP_W'(1)) == CMP_W'(PHASE_PAD);
                  pad_cnt_in = pad_cnt_ff + PAD_W'(1);
                  state_in   = ST_MAC;
               end else begin
                  if (end_ff) begin
                     scan_pos_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Coefficient conversion: eff = c + trunc(c / (2^F-1)), sign handled apart.
   // The quotient comes from repeated folding of the high part onto the low part.
   assign raw_mag = csr_data[COEFF_RAW_W-1] ? (COEFF_RAW_W'(0) - csr_data) : csr_data;
   assign cnv_hi  = cnv_n_ff >> FRAC_BITS;
   assign cnv_lo  = cnv_n_ff & DEN;
   assign cnv_qf  = cnv_q_ff + ((cnv_n_ff == DEN) ? CNV_W'(1) : CNV_W'(0));
   assign cnv_sum = COEFF_W'(cnv_mag_ff) + COEFF_W'(cnv_qf);

   always_comb begin
      cnv_busy_in = cnv_busy_ff;
      cnv_idx_in  = cnv_idx_ff;
      cnv_neg_in  = cnv_neg_ff;
      cnv_mag_in  = cnv_mag_ff;
      cnv_n_in    = cnv_n_ff;
      cnv_q_in    = cnv_q_ff;
      coeff_in    = coeff_ff;
      if (cnv_busy_ff) begin
         if (cnv_hi != '0) begin
            cnv_q_in = cnv_q_ff + cnv_hi;
            cnv_n_in = cnv_hi + cnv_lo;
         end else begin
            for (int i = 0; i < NUM_REGS; i++) begin
               if (cnv_idx_ff == REG_IDX_W'(i)) begin
                  coeff_in[i] = cnv_neg_ff ? -$signed(cnv_sum) : $signed(cnv_sum);
               end
            end
            cnv_busy_in = 1'b0;
         end
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(NUM_REGS))) begin
         cnv_busy_in = 1'b1;
         cnv_idx_in  = REG_IDX_W'(csr_index);
         cnv_neg_in  = csr_data[COEFF_RAW_W-1];
         cnv_mag_in  = raw_mag;
         cnv_n_in    = CNV_W'(raw_mag);
         cnv_q_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         pad_cnt_ff   <= '0;
         scan_pos_ff  <= '0;
         last_ff      <= '0;
         end_ff       <= 1'b0;
         emit_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnv_busy_ff  <= 1'b0;
         for (int i = 0; i < FILTER_ORDER; i++) begin
            delay_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_REGS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         pad_cnt_ff   <= pad_cnt_in;
         scan_pos_ff  <= scan_pos_in;
         last_ff      <= last_in;
         end_ff       <= end_in;
         emit_ff      <= emit_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         cnv_busy_ff  <= cnv_busy_in;
         delay_ff     <= delay_in;
         coeff_ff     <= coeff_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      cnv_idx_ff  <= cnv_idx_in;
      cnv_neg_ff  <= cnv_neg_in;
      cnv_mag_ff  <= cnv_mag_in;
      cnv_n_ff    <= cnv_n_in;
      cnv_q_ff    <= cnv_q_in;
   end

endmodule

FILE: rtl/lrff_checker.sv
// Port-level assertion checker for the lidar range filter, bound to the top level.
`timescale 1ns / 1ps
`include "lidar_range_fir_filter_assert.svh"

module lrff_checker
   import lrff_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_data_type           rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index
);

   // A stalled result holds its value.
   `LRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // A coefficient write starts the conversion, which blocks both channels.
   `LRF_ASSERT_NEXT(a_csr_busy, csr_valid && csr_ready && (csr_index < CSR_INDEX_W'(NUM_REGS)), !csr_ready && !req_ready, "coefficient write did not block")

   // No item is taken while a coefficient is being converted.
   `LRF_ASSERT_IMPL(a_cnv_blocks_req, !csr_ready, !req_ready, "item accepted during conversion")

   // A new result is only produced while an item is in work.
   `LRF_ASSERT_IMPL(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready), "result appeared while idle")

endmodule

bind lidar_range_fir_filter lrff_checker u_lrff_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index)
);

FILE: sim/testbench.sv
// Self-checking testbench for the lidar range FIR filter, with its own predictor.
`timescale 1ns / 1ps

module testbench;
   import lrff_pkg::*;

   // Run control.
   localparam int CLOCK_HALF_NS = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int DRAIN_CYCLES  = 50;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 85;
   localparam int RANDOM_PHASES = 6;
   localparam int TIMEOUT_NS    = 30_000_000;

   // Output scaling divides the wrapped sum by this before the final shift.
   localparam int RANGE_DIVISOR = 100;

   // Coefficient extremes and the two spare register indexes that the block ignores.
   localparam logic [COEFF_RAW_W-1:0] COEFF_MAX  = 16'h7fff;
   localparam logic [COEFF_RAW_W-1:0] COEFF_MIN  = 16'h8000;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   // Sample word extremes: all clear, the kept range bits set, all set, and only the upper bits set.
   localparam logic [SAMPLE_WORD_W-1:0] WORD_ZERO  = 16'h0000;
   localparam logic [SAMPLE_WORD_W-1:0] WORD_RANGE = 16'h1fff;
   localparam logic [SAMPLE_WORD_W-1:0] WORD_FULL  = 16'hffff;
   localparam logic [SAMPLE_WORD_W-1:0] WORD_HIGH  = 16'he000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_data_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_data_type           rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COEFF_RAW_W-1:0] csr_data;

   // The block under test runs with its default parameters, which the predictor mirrors.
   lidar_range_fir_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #CLOCK_HALF_NS clock = 1'b1;
      #CLOCK_HALF_NS clock = 1'b0;
   end

   // Predictor state: raw coefficients as written, the delay line of scaled samples,
   // the count of samples kept in the current scan and the last kept scaled sample.
   logic [COEFF_RAW_W-1:0] coeff_copy [NUM_REGS];
   logic [SUM_W-1:0]       tap_hist [FILTER_ORDER_DEF];
   int                     scan_len;
   logic [SUM_W-1:0]       pad_sample;

   // Range results still owed by the block, oldest first.
   rsp_data_type expected_ranges [$];

   // Coefficients that the next register load will write.
   logic [COEFF_RAW_W-1:0] coeff_plan [NUM_REGS];

   // Idling controls. The quiet flags switch random gaps off on one side. A long hold
   // of the receiver is asked for by bumping holds_asked; the sink counts it out.
   bit source_quiet;
   bit sink_quiet;
   int holds_asked;
   int hold_len;
   int holds_done  = 0;
   int sink_stall  = 0;
   int error_count = 0;
   rsp_data_type range_want;

   // Gap lengths: mostly short, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(9) != 0) return $urandom_range(4);
      return $urandom_range(60, 15);
   endfunction

   // The block converts each raw coefficient c to trunc(c * 2^F / (2^F - 1)).
   function automatic longint tap_gain(input int k);
      longint raw;
      longint unity;
      if (k >= NUM_REGS) return 0;
      raw   = longint'($signed(coeff_copy[k]));
      unity = longint'(1) <<< FRAC_BITS_DEF;
      return (raw * unity) / (unity - 1);
   endfunction

   // One filter run: each tap product is floored by F bits before the sum, and the
   // new sample then shifts into the delay line.
   function automatic longint filter_sample(input logic [SUM_W-1:0] x);
      longint acc;
      longint xv;
      longint hv;
      xv  = longint'(x);
      acc = (tap_gain(0) * xv) >>> FRAC_BITS_DEF;
      for (int j = 1; j <= FILTER_ORDER_DEF; j++) begin
         hv  = longint'(tap_hist[j - 1]);
         acc += (tap_gain(j) * hv) >>> FRAC_BITS_DEF;
      end
      for (int j = FILTER_ORDER_DEF - 1; j > 0; j--) tap_hist[j] = tap_hist[j - 1];
      tap_hist[0] = x;
      return acc;
   endfunction

   // The sum wraps to 32 bits, is divided toward zero, floored by F-1 bits and cut to
   // 16 bits. Anything past one byte is out of range; zero is lifted to the minimum.
   function automatic logic [RANGE_W-1:0] range_code(input longint y);
      int                   wrapped;
      int                   quot;
      int                   shifted;
      logic [RANGE_T_W-1:0] t;
      wrapped = y[SUM_W-1:0];
      quot    = wrapped / RANGE_DIVISOR;
      shifted = quot >>> (FRAC_BITS_DEF - 1);
      t       = shifted[RANGE_T_W-1:0];
      if (t > RANGE_T_W'(RANGE_MAX)) return RANGE_OUT_OF_RANGE;
      if (t == '0) return RANGE_MIN_CODE;
      return t[RANGE_W-1:0];
   endfunction

   // Works out every result that one accepted sample causes and queues them.
   function automatic void predict_ranges(input req_data_type item);
      logic [SUM_W-1:0]   x;
      longint             y;
      logic [RANGE_W-1:0] codes [$];
      rsp_data_type       r;
      // Past the maximum scan length a sample is dropped without a filter run.
      if (scan_len < MAX_SCAN_LEN_DEF) begin
         x = '0;
         x[SAMPLE_BITS-1:0] = item.sample_word[SAMPLE_BITS-1:0];
         x = x << FRAC_BITS_DEF;
         y = filter_sample(x);
         pad_sample = x;
         // The first PHASE_PAD runs of a scan only prime the phase delay.
         if (scan_len >= PHASE_PAD_DEF) codes.push_back(range_code(y));
         scan_len++;
      end
      // A scan end pads with copies of the last kept sample, even if it was dropped.
      if (item.scan_end) begin
         for (int j = 0; j < PHASE_PAD_DEF; j++) begin
            y = filter_sample(pad_sample);
            if (scan_len + j >= PHASE_PAD_DEF) codes.push_back(range_code(y));
         end
         scan_len = 0;
      end
      foreach (codes[i]) begin
         r.range_byte = codes[i];
         r.last_out   = item.scan_end && (i == codes.size() - 1);
         expected_ranges.push_back(r);
      end
   endfunction

   // Receiver. Inputs are sampled just after the edge, so they hold the values that
   // the transfer at that edge saw. A requested long hold takes precedence over the
   // random stalls and is counted here cycle by cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_asked;
         sink_stall <= hold_len;
         rsp_ready  <= 1'b0;
      end else if (sink_stall > 0) begin
         sink_stall <= sink_stall - 1;
         rsp_ready  <= 1'b0;
      end else if (!sink_quiet && $urandom_range(99) < 20) begin
         sink_stall <= pick_gap();
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Checker: every result transfer is matched against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ranges.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual range_byte %0d last_out %0b",
                     $time, rsp_data.range_byte, rsp_data.last_out);
            error_count++;
         end else begin
            range_want = expected_ranges.pop_front();
            if (rsp_data.range_byte !== range_want.range_byte) begin
               $display("%0t: range_byte mismatch, expected %0d, actual %0d",
                        $time, range_want.range_byte, rsp_data.range_byte);
               error_count++;
            end
            if (rsp_data.last_out !== range_want.last_out) begin
               $display("%0t: last_out mismatch, expected %0b, actual %0b",
                        $time, range_want.last_out, rsp_data.last_out);
               error_count++;
            end
         end
      end
   end

   // Offers one sample and holds it until the transfer, then predicts its results.
   // Valid stays high into the next call when no gap follows.
   task automatic send_sample(input logic [SAMPLE_WORD_W-1:0] word, input logic end_flag);
      req_data_type item;
      int           gap;
      item.sample_word = word;
      item.scan_end    = end_flag;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_ranges(item);
      if (!source_quiet) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops offering, waits for every owed result, then lets the block settle so a
   // register write only ever lands while it is idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes coeff_plan into the tap registers back to back; with_spare adds writes
   // to two unused indexes, which must leave the filter unchanged.
   task automatic load_coeffs(input bit with_spare);
      int                     count;
      logic [CSR_INDEX_W-1:0] idx;
      logic [COEFF_RAW_W-1:0] value;
      count = with_spare ? NUM_REGS + 2 : NUM_REGS;
      for (int k = 0; k < count; k++) begin
         if (k < NUM_REGS) begin
            idx   = CSR_INDEX_W'(k);
            value = coeff_plan[k];
         end else if (k == NUM_REGS) begin
            idx   = REG_SPARE_LO;
            value = COEFF_RAW_W'($urandom);
         end else begin
            idx   = REG_SPARE_HI;
            value = COEFF_RAW_W'($urandom);
         end
         csr_index <= idx;
         csr_data  <= value;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         if (idx < CSR_INDEX_W'(NUM_REGS)) coeff_copy[idx] = value;
      end
      csr_valid <= 1'b0;
   endtask

   // With the reset coefficients every sum is zero, so every result is the minimum
   // code. The words cover the field extremes and the ignored upper bits.
   task automatic test_reset_coeffs();
      send_sample(WORD_ZERO, 1'b0);
      send_sample(WORD_FULL, 1'b0);
      send_sample(WORD_RANGE, 1'b0);
      send_sample(WORD_HIGH, 1'b0);
      send_sample(16'h2000, 1'b0);
      send_sample(16'h1234, 1'b1);
      drain_results();
   endtask

   // Scans shorter than the phase delay, so that padding yields only part of its runs
   // as results, and one exactly as long.
   task automatic test_short_scans();
      coeff_plan = '{16'd8000, 16'd4000, 16'd2000, 16'd1000, 16'd500};
      load_coeffs(1'b1);
      send_sample(WORD_RANGE, 1'b1);
      send_sample(16'h0fff, 1'b0);
      send_sample(WORD_RANGE, 1'b1);
      send_sample(WORD_FULL, 1'b0);
      send_sample(16'h0800, 1'b0);
      send_sample(WORD_ZERO, 1'b0);
      send_sample(16'h1000, 1'b1);
      drain_results();
   endtask

   // Extreme coefficients give sums far above the byte range and, with negative
   // taps, below zero; alternating signs mix positive and negative tap products.
   task automatic test_extreme_coeffs();
      coeff_plan = '{COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX};
      load_coeffs(1'b0);
      send_sample(WORD_RANGE, 1'b0);
      send_sample(WORD_RANGE, 1'b0);
      send_sample(WORD_FULL, 1'b1);
      drain_results();
      coeff_plan = '{COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN};
      load_coeffs(1'b0);
      send_sample(WORD_RANGE, 1'b0);
      send_sample(16'h0001, 1'b1);
      drain_results();
      coeff_plan = '{COEFF_MAX, COEFF_MIN, COEFF_MAX, COEFF_MIN, COEFF_MAX};
      load_coeffs(1'b0);
      send_sample(WORD_RANGE, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(WORD_RANGE, 1'b1);
      drain_results();
   endtask

   // A scan that runs past the maximum length: the extra samples are dropped, and
   // the dropped scan end still pads with the last kept sample.
   task automatic test_long_scan();
      logic [SAMPLE_WORD_W-1:0] word;
      for (int k = 0; k < NUM_REGS; k++) coeff_plan[k] = COEFF_RAW_W'($urandom_range(6000));
      load_coeffs(1'b0);
      for (int i = 0; i < MAX_SCAN_LEN_DEF + 5; i++) begin
         word = SAMPLE_WORD_W'($urandom);
         send_sample(word, i == MAX_SCAN_LEN_DEF + 4);
      end
      drain_results();
   endtask

   // The receiver holds off for a long stretch while samples keep coming without
   // gaps, so the output register fills and the block stops taking input.
   task automatic test_backpressure();
      logic [SAMPLE_WORD_W-1:0] word;
      source_quiet = 1'b1;
      hold_len     = HOLD_CYCLES;
      holds_asked++;
      for (int s = 0; s < 3; s++) begin
         for (int i = 0; i < 6; i++) begin
            word = SAMPLE_WORD_W'($urandom);
            send_sample(word, i == 5);
         end
      end
      source_quiet = 1'b0;
      drain_results();
   endtask

   // Random phases, each under a coefficient setting of its own. Most scans are long
   // enough to get past the phase delay; the rest are short ones. The last phase
   // runs with no idling on either side.
   task automatic test_random_phases();
      int                       sent;
      int                       len;
      logic [SAMPLE_WORD_W-1:0] word;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            case (phase)
               0: coeff_plan[k] = COEFF_RAW_W'($urandom_range(9000));
               1: coeff_plan[k] = COEFF_RAW_W'($urandom_range(16000) - 8000);
               2: coeff_plan[k] = COEFF_RAW_W'($urandom);
               3: begin
                  case ($urandom_range(3))
                     0: coeff_plan[k] = COEFF_MAX;
                     1: coeff_plan[k] = COEFF_MIN;
                     2: coeff_plan[k] = '0;
                     default: coeff_plan[k] = COEFF_RAW_W'($urandom);
                  endcase
               end
               4: coeff_plan[k] = COEFF_RAW_W'($urandom_range(2000));
               default: coeff_plan[k] = COEFF_RAW_W'($urandom_range(9000));
            endcase
         end
         load_coeffs(phase == 2);
         source_quiet = (phase == RANDOM_PHASES - 1);
         sink_quiet   = (phase == RANDOM_PHASES - 1);
         sent = 0;
         while (sent < RANDOM_ITEMS) begin
            len = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : $urandom_range(14, 5);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(11))
                  0: word = WORD_ZERO;
                  1: word = WORD_RANGE;
                  2: word = WORD_FULL;
                  default: word = SAMPLE_WORD_W'($urandom);
               endcase
               send_sample(word, i == len - 1);
            end
            sent += len;
         end
         drain_results();
      end
      source_quiet = 1'b0;
      sink_quiet   = 1'b0;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      source_quiet = 1'b0;
      sink_quiet   = 1'b0;
      holds_asked  = 0;
      hold_len     = 0;
      scan_len     = 0;
      pad_sample   = '0;
      foreach (coeff_copy[k]) coeff_copy[k] = '0;
      foreach (tap_hist[k]) tap_hist[k] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_coeffs();
      test_short_scans();
      test_extreme_coeffs();
      test_long_scan();
      test_backpressure();
      test_random_phases();

      if (error_count == 0) begin
         $display("lidar_range_fir_filter test passed");
      end else begin
         $display("lidar_range_fir_filter test failed");
      end
      $finish;
   end

   // Watchdog: a stuck handshake or a missing result ends the run here.
   initial begin
      #TIMEOUT_NS;
      $display("lidar_range_fir_filter test failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lrff_pkg.sv
rtl/lidar_range_fir_filter.sv
rtl/lrff_checker.sv
sim/testbench.sv
